@@ rtl/bcu_pkg.sv @@
// ----------------------------------------------------------------------------
// Binomial coefficient unit package
// Status codes, micro-operation and jump codes, the control word and the
// microcode program for the sequencer and the datapath.
// ----------------------------------------------------------------------------
package bcu_pkg;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NEG   = 2'd1;
    localparam logic [1:0] ST_BIG_K = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    localparam int PC_W = 3;

    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [2:0] {
        OP_ACCEPT,
        OP_CHECK,
        OP_MUL_INIT,
        OP_MUL_STEP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_UPDATE,
        OP_EMIT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_BAD,
        COND_FINISH,
        COND_CNT_NZ,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        uop_t  op;
        cond_t cond;
        pc_t   target;
    } ctrl_word_t;

    typedef struct packed {
        logic in_valid;
        logic bad;
        logic finish;
        logic cnt_nz;
        logic out_busy;
    } dp_flags_t;

    localparam pc_t PC_FETCH    = 3'd0;
    localparam pc_t PC_CHECK    = 3'd1;
    localparam pc_t PC_LOOP     = 3'd2;
    localparam pc_t PC_MUL      = 3'd3;
    localparam pc_t PC_DIV_INIT = 3'd4;
    localparam pc_t PC_DIV      = 3'd5;
    localparam pc_t PC_UPDATE   = 3'd6;
    localparam pc_t PC_EMIT     = 3'd7;

    // A step jumps to its target when its condition holds and otherwise
    // falls through to the next address; the last step wraps to fetch.
    function automatic ctrl_word_t ucode_rom(input pc_t addr);
        ctrl_word_t w;
        unique case (addr)
            PC_FETCH:    w = '{op: OP_ACCEPT,   cond: COND_NO_IN,    target: PC_FETCH};
            PC_CHECK:    w = '{op: OP_CHECK,    cond: COND_BAD,      target: PC_EMIT};
            PC_LOOP:     w = '{op: OP_MUL_INIT, cond: COND_FINISH,   target: PC_EMIT};
            PC_MUL:      w = '{op: OP_MUL_STEP, cond: COND_CNT_NZ,   target: PC_MUL};
            PC_DIV_INIT: w = '{op: OP_DIV_INIT, cond: COND_NEVER,    target: PC_FETCH};
            PC_DIV:      w = '{op: OP_DIV_STEP, cond: COND_CNT_NZ,   target: PC_DIV};
            PC_UPDATE:   w = '{op: OP_UPDATE,   cond: COND_ALWAYS,   target: PC_LOOP};
            PC_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: PC_EMIT};
            default:     w = '{op: OP_ACCEPT,   cond: COND_ALWAYS,   target: PC_FETCH};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/bcu_if.sv @@
// ----------------------------------------------------------------------------
// Binomial coefficient unit channels
// Valid/ready channels for the argument word and the result word.
// ----------------------------------------------------------------------------
interface bcu_in_if #(
    parameter int ARG_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [ARG_WIDTH-1:0] n_value;
    logic signed [ARG_WIDTH-1:0] k_value;

    modport source (output valid, output n_value, output k_value, input ready);
    modport sink   (input valid, input n_value, input k_value, output ready);
endinterface

interface bcu_out_if #(
    parameter int COUNT_WIDTH = 64
);
    logic                   valid;
    logic                   ready;
    logic [COUNT_WIDTH-1:0] count;
    logic [1:0]             status;

    modport source (output valid, output count, output status, input ready);
    modport sink   (input valid, input count, input status, output ready);
endinterface

@@ rtl/bcu_sequencer.sv @@
// ----------------------------------------------------------------------------
// Binomial coefficient unit sequencer
// Step counter over the microcode program with conditional jumps.
// ----------------------------------------------------------------------------
module bcu_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  bcu_pkg::dp_flags_t flags,
    output bcu_pkg::uop_t      op
);
    import bcu_pkg::*;

    pc_t        pc_reg;
    pc_t        pc_next;
    ctrl_word_t word;
    logic       take;

    always_comb
    begin
        word = ucode_rom(pc_reg);
        unique case (word.cond)
            COND_NEVER:    take = 1'b0;
            COND_ALWAYS:   take = 1'b1;
            COND_NO_IN:    take = !flags.in_valid;
            COND_BAD:      take = flags.bad;
            COND_FINISH:   take = flags.finish;
            COND_CNT_NZ:   take = flags.cnt_nz;
            COND_OUT_BUSY: take = flags.out_busy;
            default:       take = 1'b0;
        endcase
        pc_next = take ? word.target : pc_t'(pc_reg + 1'b1);
        op      = word.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= PC_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

@@ rtl/bcu_datapath.sv @@
// ----------------------------------------------------------------------------
// Binomial coefficient unit datapath
// Argument checks, shift-add multiplier, restoring divider and result word
// register, each driven by the current micro-operation.
// ----------------------------------------------------------------------------
module bcu_datapath #(
    parameter int ARG_WIDTH   = 16,
    parameter int COUNT_WIDTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bcu_pkg::uop_t      op,
    output bcu_pkg::dp_flags_t flags,
    bcu_in_if.sink             in_ch,
    bcu_out_if.source          out_ch
);
    import bcu_pkg::*;

    localparam int MW    = ARG_WIDTH - 1;
    localparam int PW    = COUNT_WIDTH + MW;
    localparam int CNT_W = $clog2(PW);

    logic [ARG_WIDTH-1:0]   n_reg, n_next;
    logic [ARG_WIDTH-1:0]   k_reg, k_next;
    logic [MW-1:0]          i_reg, i_next;
    logic [MW-1:0]          m_reg, m_next;
    logic [MW-1:0]          rem_reg, rem_next;
    logic [PW-1:0]          prod_reg, prod_next;
    logic [COUNT_WIDTH-1:0] c_reg, c_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [1:0]             status_reg, status_next;
    logic                   out_valid_reg, out_valid_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [1:0]             out_status_reg, out_status_next;

    logic                 neg;
    logic                 big_k;
    logic [ARG_WIDTH-1:0] n_minus_k;
    logic [MW-1:0]        divisor;
    logic [MW:0]          shifted;
    logic [MW:0]          diff;
    logic                 ge;
    logic                 out_busy;

    assign neg       = n_reg[ARG_WIDTH-1] | k_reg[ARG_WIDTH-1];
    assign big_k     = k_reg > n_reg;
    assign n_minus_k = n_reg - k_reg;
    assign divisor   = MW'(i_reg + 1'b1);
    assign shifted   = {rem_reg, prod_reg[PW-1]};
    assign diff      = shifted - {1'b0, divisor};
    assign ge        = shifted >= {1'b0, divisor};
    assign out_busy  = out_valid_reg && !out_ch.ready;

    assign flags.in_valid = in_ch.valid;
    assign flags.bad      = neg || big_k;
    assign flags.finish   = (i_reg == k_reg[MW-1:0]) || (status_reg == ST_OVF);
    assign flags.cnt_nz   = cnt_reg != '0;
    assign flags.out_busy = out_busy;

    assign in_ch.ready   = (op == OP_ACCEPT);
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.count  = count_reg;
    assign out_ch.status = out_status_reg;

    always_comb
    begin
        n_next          = n_reg;
        k_next          = k_reg;
        i_next          = i_reg;
        m_next          = m_reg;
        rem_next        = rem_reg;
        prod_next       = prod_reg;
        c_next          = c_reg;
        cnt_next        = cnt_reg;
        status_next     = status_reg;
        count_next      = count_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !out_ch.ready;

        unique case (op)
            OP_ACCEPT:
            begin
                n_next = in_ch.n_value;
                k_next = in_ch.k_value;
            end
            OP_CHECK:
            begin
                i_next = '0;
                if (neg)
                begin
                    c_next      = '0;
                    status_next = ST_NEG;
                end
                else if (big_k)
                begin
                    c_next      = '0;
                    status_next = ST_BIG_K;
                end
                else
                begin
                    c_next      = COUNT_WIDTH'(1);
                    status_next = ST_OK;
                    if (k_reg > n_minus_k)
                    begin
                        k_next = n_minus_k;
                    end
                end
            end
            OP_MUL_INIT:
            begin
                prod_next = '0;
                m_next    = MW'(n_reg[MW-1:0] - i_reg);
                cnt_next  = CNT_W'(MW - 1);
            end
            OP_MUL_STEP:
            begin
                prod_next = {prod_reg[PW-2:0], 1'b0}
                          + (m_reg[MW-1] ? PW'(c_reg) : '0);
                m_next    = {m_reg[MW-2:0], 1'b0};
                cnt_next  = CNT_W'(cnt_reg - 1'b1);
            end
            OP_DIV_INIT:
            begin
                rem_next = '0;
                cnt_next = CNT_W'(PW - 1);
            end
            OP_DIV_STEP:
            begin
                rem_next  = ge ? diff[MW-1:0] : shifted[MW-1:0];
                prod_next = {prod_reg[PW-2:0], ge};
                cnt_next  = CNT_W'(cnt_reg - 1'b1);
            end
            OP_UPDATE:
            begin
                if (prod_reg[PW-1:COUNT_WIDTH] != '0)
                begin
                    c_next      = '1;
                    status_next = ST_OVF;
                end
                else
                begin
                    c_next = prod_reg[COUNT_WIDTH-1:0];
                    i_next = MW'(i_reg + 1'b1);
                end
            end
            OP_EMIT:
            begin
                if (!out_busy)
                begin
                    out_valid_next  = 1'b1;
                    count_next      = c_reg;
                    out_status_next = status_reg;
                end
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        k_reg          <= k_next;
        i_reg          <= i_next;
        m_reg          <= m_next;
        rem_reg        <= rem_next;
        prod_reg       <= prod_next;
        c_reg          <= c_next;
        cnt_reg        <= cnt_next;
        count_reg      <= count_next;
        out_status_reg <= out_status_next;
    end

`ifndef SYNTHESIS
    a_div_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DIV_STEP) |-> (rem_reg < divisor))
        else $error("divider remainder not below divisor");

    a_reject_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == ST_NEG || out_status_reg == ST_BIG_K))
        |-> (count_reg == '0))
        else $error("rejected arguments carry a nonzero count");

    a_overflow_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_status_reg == ST_OVF) |-> (count_reg == '1))
        else $error("overflow result is not saturated");

    a_emit_loads_word: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_EMIT && !out_busy) |=> (out_valid_reg && count_reg == $past(c_reg)))
        else $error("result word not loaded at emit");
`endif

endmodule

@@ rtl/binomial_coefficient_unit.sv @@
// ----------------------------------------------------------------------------
// Binomial coefficient unit
// Returns C(n,k) with a status code for each word of two signed arguments.
// ----------------------------------------------------------------------------
// Arguments arrive on in_ch (n_value, k_value) and one result word leaves on
// out_ch (count, status) for every argument word, in order.
// Status is ok, negative argument, k exceeds n, or overflow; a rejected
// word carries count zero and an overflow carries count all ones.
// The count is built by steps count = count * (n - i) / (i + 1) for i below
// min(k, n - k), stopping early at overflow.
// Each step loads the multiplier, runs the shift-add multiplier and then
// the restoring divider, one bit per cycle, and ends with an update of the
// count; a rejected word goes from the check straight to emit. A word takes
// at most 34 steps at the default widths because larger results overflow.
// One word is in work at a time.
// The result sits in an output register, so a new argument word is taken
// while the previous result still waits; a stalled receiver holds the
// sequencer only when a second result is ready to be written.
// Reset empties the output register and returns the sequencer to fetch.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit #(
    parameter int ARG_WIDTH   = 16,
    parameter int COUNT_WIDTH = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    bcu_in_if.sink    in_ch,
    bcu_out_if.source out_ch
);
    import bcu_pkg::*;

    uop_t      op;
    dp_flags_t flags;

    bcu_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .op    (op)
    );

    bcu_datapath #(
        .ARG_WIDTH   (ARG_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (op),
        .flags  (flags),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

@@ dv/bcu_checker.sv @@
// ----------------------------------------------------------------------------
// Binomial coefficient unit checker
// Watches the argument and result channels. For each accepted argument word
// it computes C(n,k) and the status exactly and queues them. Each accepted
// result word is compared, field by field, with the oldest queued value.
// The failure count and the number of results still owed go to the top.
// ----------------------------------------------------------------------------
module bcu_checker #(
    parameter int ARG_W   = 16,
    parameter int COUNT_W = 64
) (
    input  logic clk,
    input  logic rst_n,
    bcu_in_if    in_ch,
    bcu_out_if   out_ch,
    output int   fail_count,
    output int   pending
);

    import bcu_pkg::*;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [1:0]         status;
    } coeff_t;

    coeff_t pending_coeffs[$];
    int     failures;

    // Exact integer form: each step computes count * (n - i) / (i + 1) in a
    // wide accumulator, which is always exact, and stops at overflow.
    function automatic coeff_t binomial_of(input logic signed [ARG_W-1:0] n,
                                           input logic signed [ARG_W-1:0] k);
        coeff_t       r;
        int           steps;
        logic [127:0] acc;
        r.count  = '0;
        r.status = ST_OK;
        if (n < 0 || k < 0)
        begin
            r.status = ST_NEG;
        end
        else if (k > n)
        begin
            r.status = ST_BIG_K;
        end
        else
        begin
            steps   = (k > n - k) ? int'(n - k) : int'(k);
            r.count = COUNT_W'(1);
            for (int i = 0; i < steps; i++)
            begin
                acc = 128'(r.count) * 128'(int'(n) - i) / 128'(i + 1);
                if (acc[127:COUNT_W] != '0)
                begin
                    r.status = ST_OVF;
                    r.count  = '1;
                    break;
                end
                r.count = acc[COUNT_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= 10)
        begin
            $display("%s", msg);
        end
    endfunction

    initial
    begin
        failures   = 0;
        fail_count = 0;
        pending    = 0;
    end

    // Results are taken before arguments so that a result can never be
    // matched against a word accepted at the same edge.
    always @(posedge clk)
    begin
        coeff_t want;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (pending_coeffs.size() == 0)
                begin
                    note_failure($sformatf("result word with none owed: count %h status %0d",
                                           out_ch.count, out_ch.status));
                end
                else
                begin
                    want = pending_coeffs.pop_front();
                    if (out_ch.count !== want.count)
                    begin
                        note_failure($sformatf("count mismatch: expected %h actual %h",
                                               want.count, out_ch.count));
                    end
                    if (out_ch.status !== want.status)
                    begin
                        note_failure($sformatf("status mismatch: expected %0d actual %0d",
                                               want.status, out_ch.status));
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                pending_coeffs.push_back(binomial_of(in_ch.n_value, in_ch.k_value));
            end
            fail_count <= failures;
            pending    <= pending_coeffs.size();
        end
    end

endmodule

@@ dv/binomial_coefficient_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Binomial coefficient unit testbench
// Drives argument words: a directed set covering the argument extremes, the
// negative, k-exceeds-n, symmetric, zero-choice and overflow cases, then a
// long receiver stall that backs up the input, then random words, mostly
// small well-formed pairs plus large n and raw noise. Both sides idle in
// random bursts except in the last stretch. The checker does all comparing.
// ----------------------------------------------------------------------------
module binomial_coefficient_unit_tb;

    localparam int ARG_W       = 16;
    localparam int COUNT_W     = 64;
    localparam int RANDOM_WORDS = 83;
    localparam int QUIET_WORDS = 25;
    localparam int HOLD_CYCLES = 600;
    localparam int STALL_LIMIT = 20000;
    localparam int TAIL_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n;
    logic hold_req;
    logic holding;
    logic quiet;
    int   fail_count;
    int   pending;
    int   idle_cycles;

    bcu_in_if  #(.ARG_WIDTH(ARG_W))     in_ch ();
    bcu_out_if #(.COUNT_WIDTH(COUNT_W)) out_ch ();

    binomial_coefficient_unit #(
        .ARG_WIDTH   (ARG_W),
        .COUNT_WIDTH (COUNT_W)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    bcu_checker #(
        .ARG_W   (ARG_W),
        .COUNT_W (COUNT_W)
    ) checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n          = 1'b0;
        hold_req       = 1'b0;
        holding        = 1'b0;
        quiet          = 1'b0;
        idle_cycles    = 0;
        in_ch.valid    = 1'b0;
        in_ch.n_value  = '0;
        in_ch.k_value  = '0;
        out_ch.ready   = 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles == STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_ch.ready <= 1'b0;
                holding      <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                holding      <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    task automatic send_word(input logic signed [ARG_W-1:0] n,
                             input logic signed [ARG_W-1:0] k);
        in_ch.valid   <= 1'b1;
        in_ch.n_value <= n;
        in_ch.k_value <= k;
        @(posedge clk);
        while (!in_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic offer_word(input logic signed [ARG_W-1:0] n,
                              input logic signed [ARG_W-1:0] k);
        send_word(n, k);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic await_drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic pick_word(output logic signed [ARG_W-1:0] n,
                             output logic signed [ARG_W-1:0] k);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            n = ARG_W'($urandom_range(0, 72));
            k = ARG_W'($urandom_range(0, int'(n)));
        end
        else if (sel < 8)
        begin
            n = ARG_W'($urandom_range(0, 32767));
            k = ARG_W'($urandom_range(0, 12));
            if ($urandom_range(0, 1) == 1)
            begin
                k = n - k;
            end
        end
        else
        begin
            n = ARG_W'($urandom);
            k = ARG_W'($urandom);
        end
    endtask

    initial
    begin
        logic signed [ARG_W-1:0] n;
        logic signed [ARG_W-1:0] k;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_word(0, 0);
        offer_word(5, 0);
        offer_word(5, 5);
        offer_word(10, 3);
        offer_word(10, 7);
        offer_word(-1, 0);
        offer_word(0, -1);
        offer_word(-32768, -32768);
        offer_word(32767, -32768);
        offer_word(-32768, 32767);
        offer_word(32767, 32767);
        offer_word(32767, 1);
        offer_word(32767, 32766);
        offer_word(3, 4);
        offer_word(0, 32767);
        offer_word(62, 31);
        offer_word(67, 33);
        offer_word(68, 34);
        offer_word(100, 50);
        offer_word(1000, 7);
        offer_word(32767, 16383);
        await_drain();

        // The output register fills, the next result waits in the
        // sequencer, and the input backs up while words keep coming.
        hold_req <= 1'b1;
        @(posedge clk);
        while (!holding)
        begin
            @(posedge clk);
        end
        hold_req <= 1'b0;
        for (int i = 1; i <= 8; i++)
        begin
            send_word(ARG_W'(i), ARG_W'(i + 1));
            send_word(ARG_W'(-i), 3);
        end
        await_drain();

        for (int i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS - QUIET_WORDS)
            begin
                quiet <= 1'b1;
            end
            pick_word(n, k);
            offer_word(n, k);
        end
        await_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
